### design/cascaded_biquad_equalizer_defines.svh
// Assertion macros shared by the equalizer modules.
`ifndef CASCADED_BIQUAD_EQUALIZER_DEFINES_SVH
`define CASCADED_BIQUAD_EQUALIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBEQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/cbeq_pkg.sv
// Package with the shared types and constants of the equalizer.
package cbeq_pkg;

    // Default configuration of the block.
    localparam int DEF_BANDS          = 7;
    localparam int DEF_SAMPLE_BITS    = 24;
    localparam int DEF_COEF_FRAC_BITS = 28;

    // Coefficient format and count per band.
    localparam int COEF_BITS = 32;
    localparam int NCOEF     = 5;

    // Transaction modes.
    localparam logic [1:0] MODE_FILTER = 2'd0;
    localparam logic [1:0] MODE_COEF   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Coefficient selectors, also the MAC step order within a band.
    localparam logic [2:0] COEF_B0 = 3'd0;
    localparam logic [2:0] COEF_B1 = 3'd1;
    localparam logic [2:0] COEF_B2 = 3'd2;
    localparam logic [2:0] COEF_A1 = 3'd3;
    localparam logic [2:0] COEF_A2 = 3'd4;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_BAND,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       issue;
        logic [2:0] k;
        logic       acc_clr;
        logic       band_done;
        logic       load_x;
        logic       coef_we;
        logic       hist_clr;
        logic       out_load;
    } t_dp_cmd;

endpackage

### design/cbeq_ctrl.sv
// Sequencing controller of the equalizer: handshakes, band and MAC step counters.
module cbeq_ctrl #(
    parameter int  BANDS = cbeq_pkg::DEF_BANDS,
    localparam int CA_W  = $clog2(cbeq_pkg::NCOEF * BANDS),
    localparam int BW    = (BANDS > 1) ? $clog2(BANDS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_mode,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output cbeq_pkg::t_dp_cmd   o_cmd,
    output logic [CA_W-1:0]     o_caddr,
    output logic [BW-1:0]       o_band_idx
);
    import cbeq_pkg::*;

    `include "cascaded_biquad_equalizer_defines.svh"

    localparam logic [2:0]    DRAIN_LAST = 3'd1;
    localparam logic [BW-1:0] LAST_BAND  = BW'(BANDS - 1);

    t_state          r_state, n_state;
    logic [2:0]      r_cnt, n_cnt;
    logic [BW-1:0]   r_band, n_band;
    logic [CA_W-1:0] r_caddr, n_caddr;
    logic            r_out_valid, n_out_valid;
    logic            accept;
    logic            out_free;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_mode == MODE_FILTER)) n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (r_cnt == COEF_A2) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (r_cnt == DRAIN_LAST) n_state = ST_BAND;
            end
            ST_BAND: begin
                n_state = (r_band == LAST_BAND) ? ST_FINISH : ST_ISSUE;
            end
            ST_FINISH: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Step, band and coefficient address counters.
    always_comb begin
        n_cnt   = '0;
        n_band  = r_band;
        n_caddr = r_caddr;
        case (r_state)
            ST_IDLE: begin
                n_band  = '0;
                n_caddr = '0;
            end
            ST_ISSUE: begin
                n_cnt   = (r_cnt == COEF_A2) ? 3'd0 : r_cnt + 3'd1;
                n_caddr = r_caddr + CA_W'(1);
            end
            ST_DRAIN: begin
                n_cnt = (r_cnt == DRAIN_LAST) ? 3'd0 : r_cnt + 3'd1;
            end
            ST_BAND: begin
                if (r_band != LAST_BAND) n_band = r_band + BW'(1);
            end
            default: n_cnt = '0;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd           = '0;
        o_cmd.k         = r_cnt;
        o_cmd.issue     = (r_state == ST_ISSUE);
        o_cmd.acc_clr   = (r_state == ST_IDLE) || (r_state == ST_BAND);
        o_cmd.band_done = (r_state == ST_BAND);
        o_cmd.load_x    = accept && (i_mode == MODE_FILTER);
        o_cmd.coef_we   = accept && (i_mode == MODE_COEF);
        o_cmd.hist_clr  = accept && (i_mode == MODE_CLEAR);
        o_cmd.out_load  = (r_state == ST_FINISH) && out_free;
    end

    // Output valid holds until its transaction completes.
    assign n_out_valid = o_cmd.out_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_band      <= '0;
            r_caddr     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_band      <= n_band;
            r_caddr     <= n_caddr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_caddr     = r_caddr;
    assign o_band_idx  = r_band;

    // A result appears only after the finishing state hands it over.
    `CBEQ_ASSERT_IMPL(a_out_from_finish, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == ST_FINISH, "result valid raised outside finish")
    // A filter transaction starts the MAC sequence in the next cycle.
    `CBEQ_ASSERT_NEXT(a_filter_starts, i_clk, i_rst_n, accept && (i_mode == MODE_FILTER), (r_state == ST_ISSUE) && (r_cnt == COEF_B0) && (r_band == '0), "filter transaction did not start band zero")
    // The band counter never leaves the configured range.
    `CBEQ_ASSERT_IMPL(a_band_range, i_clk, i_rst_n, r_state != ST_IDLE, r_band <= LAST_BAND, "band counter out of range")

endmodule

### design/cbeq_dp.sv
// Datapath of the equalizer: coefficient and history memories, shared MAC, rounding.
module cbeq_dp #(
    parameter int  BANDS          = cbeq_pkg::DEF_BANDS,
    parameter int  SAMPLE_BITS    = cbeq_pkg::DEF_SAMPLE_BITS,
    parameter int  COEF_FRAC_BITS = cbeq_pkg::DEF_COEF_FRAC_BITS,
    localparam int CA_W           = $clog2(cbeq_pkg::NCOEF * BANDS),
    localparam int BW             = (BANDS > 1) ? $clog2(BANDS) : 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cbeq_pkg::t_dp_cmd                     i_cmd,
    input  logic [CA_W-1:0]                       i_caddr,
    input  logic [BW-1:0]                         i_band_idx,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_in,
    input  logic [2:0]                            i_band,
    input  logic [2:0]                            i_coef_sel,
    input  logic signed [cbeq_pkg::COEF_BITS-1:0] i_coef_value,
    output logic signed [SAMPLE_BITS-1:0]         o_sample_out,
    output logic                                  o_clipped
);
    import cbeq_pkg::*;

    `include "cascaded_biquad_equalizer_defines.svh"

    localparam int SB   = SAMPLE_BITS;
    localparam int CB   = COEF_BITS;
    localparam int PW   = CB + SB;
    localparam int AW   = PW + 3;
    localparam int NC   = NCOEF * BANDS;
    localparam int WA_W = (CA_W > 6) ? CA_W : 6;

    localparam logic signed [CB-1:0] COEF_ONE = CB'(1) << COEF_FRAC_BITS;
    localparam logic signed [AW-1:0] RND_HALF = AW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] SMAX     = (AW'(1) << (SB - 1)) - AW'(1);
    localparam logic signed [AW-1:0] SMIN     = ~SMAX;

    // Coefficient memory with per-entry valid bits; an unwritten entry reads as bypass.
    logic signed [CB-1:0]   r_coef_mem [NC];
    logic [NC-1:0]          r_coef_vld;
    logic signed [CB-1:0]   r_coef_rd;
    logic                   r_coef_rv;

    // History memory, one row per band: x1, x2, y1, y2 from the low end.
    logic [4*SB-1:0]        r_hist_mem [BANDS];
    logic [BANDS-1:0]       r_hist_vld;
    logic [4*SB-1:0]        r_hist_rd;
    logic                   r_hist_rv;

    logic signed [SB-1:0]   r_x;
    logic                   r_clip;
    logic                   r_vb, r_vc;
    logic [2:0]             r_k_b;
    logic                   r_sub_c;
    logic signed [PW-1:0]   r_prod;
    logic signed [AW-1:0]   r_acc;
    logic signed [SB-1:0]   r_sample_out;
    logic                   r_clipped;

    logic [WA_W-1:0]        wr_full;
    logic [CA_W-1:0]        wr_addr;
    logic                   wr_ok;
    logic signed [CB-1:0]   coef_op;
    logic signed [SB-1:0]   samp_op;
    logic signed [SB-1:0]   h_x1, h_x2, h_y1, h_y2;
    logic signed [PW-1:0]   mult;
    logic signed [AW-1:0]   rnd_sum;
    logic signed [AW-1:0]   rnd_shift;
    logic signed [SB-1:0]   y_sat;
    logic                   y_clip;

    // Coefficient write address and range check.
    assign wr_full = WA_W'(i_band) * WA_W'(NCOEF) + WA_W'(i_coef_sel);
    assign wr_addr = wr_full[CA_W-1:0];
    assign wr_ok   = (int'(i_band) < BANDS) && (i_coef_sel <= COEF_A2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_we && wr_ok) r_coef_mem[wr_addr] <= i_coef_value;
        if (i_cmd.issue) r_coef_rd <= r_coef_mem[i_caddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld <= '0;
        end else if (i_cmd.coef_we && wr_ok) begin
            r_coef_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) r_coef_rv <= r_coef_vld[i_caddr];
    end

    // History rows: read during the MAC steps, written back when the band finishes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.band_done) r_hist_mem[i_band_idx] <= {h_y1, y_sat, h_x1, r_x};
        if (i_cmd.issue) begin
            r_hist_rd <= r_hist_mem[i_band_idx];
            r_hist_rv <= r_hist_vld[i_band_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
        end else if (i_cmd.hist_clr) begin
            r_hist_vld <= '0;
        end else if (i_cmd.band_done) begin
            r_hist_vld[i_band_idx] <= 1'b1;
        end
    end

    assign h_x1 = r_hist_rv ? r_hist_rd[SB-1:0]      : '0;
    assign h_x2 = r_hist_rv ? r_hist_rd[2*SB-1:SB]   : '0;
    assign h_y1 = r_hist_rv ? r_hist_rd[3*SB-1:2*SB] : '0;
    assign h_y2 = r_hist_rv ? r_hist_rd[4*SB-1:3*SB] : '0;

    // Operand selection for the current MAC step.
    always_comb begin
        if (r_coef_rv) begin
            coef_op = r_coef_rd;
        end else begin
            coef_op = (r_k_b == COEF_B0) ? COEF_ONE : '0;
        end
        case (r_k_b)
            COEF_B0: samp_op = r_x;
            COEF_B1: samp_op = h_x1;
            COEF_B2: samp_op = h_x2;
            COEF_A1: samp_op = h_y1;
            default: samp_op = h_y2;
        endcase
    end

    assign mult = coef_op * samp_op;

    // MAC pipeline: read, multiply, accumulate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_vb <= i_cmd.issue;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k_b   <= i_cmd.k;
        r_sub_c <= (r_k_b == COEF_A1) || (r_k_b == COEF_A2);
        r_prod  <= mult;
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_vc) begin
            if (r_sub_c) begin
                r_acc <= r_acc - {{(AW - PW){r_prod[PW-1]}}, r_prod};
            end else begin
                r_acc <= r_acc + {{(AW - PW){r_prod[PW-1]}}, r_prod};
            end
        end
    end

    // Round half up, then saturate to the sample range.
    assign rnd_sum   = r_acc + RND_HALF;
    assign rnd_shift = rnd_sum >>> COEF_FRAC_BITS;

    always_comb begin
        y_clip = 1'b0;
        y_sat  = rnd_shift[SB-1:0];
        if (rnd_shift > SMAX) begin
            y_sat  = SMAX[SB-1:0];
            y_clip = 1'b1;
        end else if (rnd_shift < SMIN) begin
            y_sat  = SMIN[SB-1:0];
            y_clip = 1'b1;
        end
    end

    // Band input and clip flag carried across the cascade.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x    <= i_sample_in;
            r_clip <= 1'b0;
        end else if (i_cmd.band_done) begin
            r_x    <= y_sat;
            r_clip <= r_clip | y_clip;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_sample_out <= r_x;
            r_clipped    <= r_clip;
        end
    end

    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

    // The multiply stage is only fed from a preceding read stage.
    `CBEQ_ASSERT_IMPL(a_pipe_order, i_clk, i_rst_n, r_vc, $past(r_vb), "multiply stage valid without a read")
    // Rounding takes place only once the MAC pipeline has drained.
    `CBEQ_ASSERT_IMPL(a_drained_round, i_clk, i_rst_n, i_cmd.band_done, !r_vb && !r_vc, "band finished with MAC steps in flight")
    // Coefficients change only while no MAC step is running.
    `CBEQ_ASSERT_IMPL(a_coef_quiet, i_clk, i_rst_n, i_cmd.coef_we, !r_vb && !r_vc && !i_cmd.issue, "coefficient written during a sample")

endmodule

### design/cascaded_biquad_equalizer.sv
// A sample transaction runs its sample through every band in turn on the single shared MAC:
// five multiplies per band, a two-stage drain and a round-and-writeback step per band. A new
// transaction is taken only once the result has moved to the output register.
// Coefficient and clear transactions are taken while idle and give no result.
// Reset is synchronous and active low: every band returns to bypass, all history reads
// as zero at once through valid bits, and no clearing pass is needed.
module cascaded_biquad_equalizer #(
    parameter int BANDS          = cbeq_pkg::DEF_BANDS,
    parameter int SAMPLE_BITS    = cbeq_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = cbeq_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_mode,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_in,
    input  logic [2:0]                            i_band,
    input  logic [2:0]                            i_coef_sel,
    input  logic signed [cbeq_pkg::COEF_BITS-1:0] i_coef_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]         o_sample_out,
    output logic                                  o_clipped
);
    import cbeq_pkg::*;

    localparam int CA_W = $clog2(NCOEF * BANDS);
    localparam int BW   = (BANDS > 1) ? $clog2(BANDS) : 1;

    t_dp_cmd         cmd;
    logic [CA_W-1:0] caddr;
    logic [BW-1:0]   band_idx;

    // Controller: handshakes and sequencing.
    cbeq_ctrl #(
        .BANDS (BANDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .o_caddr     (caddr),
        .o_band_idx  (band_idx)
    );

    // Datapath: storage, MAC and output payload.
    cbeq_dp #(
        .BANDS          (BANDS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_caddr      (caddr),
        .i_band_idx   (band_idx),
        .i_sample_in  (i_sample_in),
        .i_band       (i_band),
        .i_coef_sel   (i_coef_sel),
        .i_coef_value (i_coef_value),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

endmodule

### tb/sv/tb_cascaded_biquad_equalizer.sv
// Self-checking testbench for the seven-band cascaded biquad equalizer.
module tb_cascaded_biquad_equalizer;
    timeunit 1ns;
    timeprecision 1ps;

    import cbeq_pkg::*;

    localparam int BANDS       = DEF_BANDS;
    localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
    localparam int FRAC_BITS   = DEF_COEF_FRAC_BITS;

    // The package names modes 0 to 2 only; mode 3 must be a no-op.
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam int ITEM_TARGET  = 1950;
    localparam int TAIL_ITEMS   = 150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8 * BANDS + 8;
    localparam int MAX_REPORTS  = 100;

    localparam longint SAT_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_MIN = -(longint'(1) << (SAMPLE_BITS - 1));
    localparam logic signed [COEF_BITS-1:0] COEF_ONE = 32'sd1 <<< FRAC_BITS;

    typedef enum int {
        PROFILE_MILD,
        PROFILE_FLAT,
        PROFILE_HOT,
        PROFILE_WILD
    } t_eq_profile;

    typedef struct {
        logic [1:0]                    mode;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [2:0]                    band;
        logic [2:0]                    sel;
        logic signed [COEF_BITS-1:0]   value;
        bit                            drain_first;
    } t_eq_xact;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          clipped;
    } t_eq_result;

    // Clock, reset and block ports.
    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_in_valid   = 1'b0;
    logic [1:0]                    i_mode       = MODE_FILTER;
    logic signed [SAMPLE_BITS-1:0] i_sample_in  = '0;
    logic [2:0]                    i_band       = '0;
    logic [2:0]                    i_coef_sel   = COEF_B0;
    logic signed [COEF_BITS-1:0]   i_coef_value = '0;
    logic                          i_out_stall  = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic signed [SAMPLE_BITS-1:0] o_sample_out;
    logic                          o_clipped;

    // Equalizer state as the testbench predicts it.
    logic signed [COEF_BITS-1:0]   band_coef [BANDS][NCOEF];
    logic signed [SAMPLE_BITS-1:0] band_x1 [BANDS];
    logic signed [SAMPLE_BITS-1:0] band_x2 [BANDS];
    logic signed [SAMPLE_BITS-1:0] band_y1 [BANDS];
    logic signed [SAMPLE_BITS-1:0] band_y2 [BANDS];

    // Stimulus and checking bookkeeping.
    t_eq_xact   xact_queue [$];
    t_eq_result equalized_due [$];
    t_eq_xact   cur_xact;
    int         items_counted     = 0;
    int         samples_predicted = 0;
    int         outputs_checked   = 0;
    int         mismatches        = 0;
    bit         stim_done         = 1'b0;
    bit         tail_phase        = 1'b0;

    cascaded_biquad_equalizer #(
        .BANDS          (BANDS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_sample_in  (i_sample_in),
        .i_band       (i_band),
        .i_coef_sel   (i_coef_sel),
        .i_coef_value (i_coef_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

    // Free-running clock, 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Runs one sample through every band in order and updates the band histories.
    function automatic t_eq_result equalize_sample(logic signed [SAMPLE_BITS-1:0] x_in);
        t_eq_result res;
        longint     x;
        longint     acc;
        x = x_in;
        res.clipped = 1'b0;
        for (int b = 0; b < BANDS; b++) begin
            acc = longint'(band_coef[b][COEF_B0]) * x
                + longint'(band_coef[b][COEF_B1]) * longint'(band_x1[b])
                + longint'(band_coef[b][COEF_B2]) * longint'(band_x2[b])
                - longint'(band_coef[b][COEF_A1]) * longint'(band_y1[b])
                - longint'(band_coef[b][COEF_A2]) * longint'(band_y2[b]);
            // Round half up, then drop the fraction bits.
            acc = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (acc > SAT_MAX) begin
                acc = SAT_MAX;
                res.clipped = 1'b1;
            end else if (acc < SAT_MIN) begin
                acc = SAT_MIN;
                res.clipped = 1'b1;
            end
            band_x2[b] = band_x1[b];
            band_x1[b] = x[SAMPLE_BITS-1:0];
            band_y2[b] = band_y1[b];
            band_y1[b] = acc[SAMPLE_BITS-1:0];
            x = acc;
        end
        res.sample = x[SAMPLE_BITS-1:0];
        return res;
    endfunction

    // Sample amplitudes: mostly full scale, some small, some at the rails.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            6, 7:    return SAMPLE_BITS'(int'($urandom_range(0, 8192)) - 4096);
            8:       return SAMPLE_BITS'($urandom_range(0, 1) ? SAT_MAX : SAT_MIN);
            9:       return SAMPLE_BITS'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Coefficients for one filter profile; mild filters stay stable.
    function automatic logic signed [COEF_BITS-1:0] pick_coef(t_eq_profile profile,
                                                              logic [2:0] sel);
        int jitter;
        jitter = int'($urandom_range(0, 1 << (FRAC_BITS - 1))) - (1 << (FRAC_BITS - 2));
        case (profile)
            PROFILE_WILD: return COEF_BITS'($urandom);
            PROFILE_FLAT: return (sel == COEF_B0) ? COEF_ONE : '0;
            PROFILE_HOT:
                return (sel == COEF_B0) ?
                    COEF_BITS'($urandom_range(1 << FRAC_BITS, 1 << (FRAC_BITS + 1))) : '0;
            default:      return (sel == COEF_B0) ? COEF_ONE + jitter : COEF_BITS'(jitter);
        endcase
    endfunction

    task automatic add_xact(logic [1:0] mode, logic signed [SAMPLE_BITS-1:0] sample,
                            logic [2:0] band, logic [2:0] sel,
                            logic signed [COEF_BITS-1:0] value, bit drain_first);
        t_eq_xact t;
        t.mode        = mode;
        t.sample      = sample;
        t.band        = band;
        t.sel         = sel;
        t.value       = value;
        t.drain_first = drain_first;
        xact_queue.push_back(t);
    endtask

    // Unused fields of each transaction carry random values.
    task automatic add_sample(logic signed [SAMPLE_BITS-1:0] x);
        add_xact(MODE_FILTER, x, 3'($urandom), 3'($urandom), COEF_BITS'($urandom), 1'b0);
        items_counted++;
    endtask

    task automatic add_coef(logic [2:0] band, logic [2:0] sel, logic signed [COEF_BITS-1:0] v);
        add_xact(MODE_COEF, SAMPLE_BITS'($urandom), band, sel, v, 1'b0);
        if (int'(band) < BANDS && sel <= COEF_A2) begin
            items_counted++;
        end
    endtask

    task automatic add_control(logic [1:0] mode, bit drain_first);
        add_xact(mode, SAMPLE_BITS'($urandom), 3'($urandom), 3'($urandom),
                 COEF_BITS'($urandom), drain_first);
        if (mode == MODE_CLEAR) begin
            items_counted++;
        end
    endtask

    // Driver: presents queued transactions and updates the prediction on acceptance.
    always @(posedge i_clk) begin : driver
        t_eq_result res;
        bit         take_next;
        static int  gap_left     = 0;
        static int  accepted_cnt = 0;
        static bit  gaps_on      = 1'b1;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            take_next = !i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                take_next = 1'b1;
                case (cur_xact.mode)
                    MODE_FILTER: begin
                        res = equalize_sample(cur_xact.sample);
                        equalized_due.push_back(res);
                        samples_predicted++;
                    end
                    MODE_COEF: begin
                        // Writes outside the band or selector range are dropped.
                        if (int'(cur_xact.band) < BANDS && cur_xact.sel <= COEF_A2) begin
                            band_coef[cur_xact.band][cur_xact.sel] = cur_xact.value;
                        end
                    end
                    MODE_CLEAR: begin
                        for (int b = 0; b < BANDS; b++) begin
                            band_x1[b] = '0;
                            band_x2[b] = '0;
                            band_y1[b] = '0;
                            band_y2[b] = '0;
                        end
                    end
                    default: ;
                endcase
                accepted_cnt++;
                if (accepted_cnt % 200 == 0) begin
                    gaps_on = ($urandom_range(0, 2) != 0);
                end
                if (gaps_on && xact_queue.size() >= TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(1, 12);
                end
            end
            tail_phase <= (xact_queue.size() < TAIL_ITEMS);
            if (take_next) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (xact_queue.size() == 0) begin
                    i_in_valid <= 1'b0;
                    stim_done  <= 1'b1;
                end else if (xact_queue[0].drain_first &&
                             samples_predicted != outputs_checked) begin
                    // Hold off until every equalized sample has come back.
                    i_in_valid <= 1'b0;
                end else begin
                    cur_xact = xact_queue.pop_front();
                    i_mode       <= cur_xact.mode;
                    i_sample_in  <= cur_xact.sample;
                    i_band       <= cur_xact.band;
                    i_coef_sel   <= cur_xact.sel;
                    i_coef_value <= cur_xact.value;
                    i_in_valid   <= 1'b1;
                end
            end
        end
    end

    // Monitor: checks each equalized sample and drives random output stalls.
    always @(posedge i_clk) begin : monitor
        t_eq_result want;
        static int  stall_left = 0;
        static int  cycle_cnt  = 0;
        static bit  stalls_on  = 1'b1;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (equalized_due.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $error("unexpected result: sample_out %0d, clipped %0b",
                               o_sample_out, o_clipped);
                    end
                    mismatches++;
                end else begin
                    want = equalized_due.pop_front();
                    if (o_sample_out !== want.sample) begin
                        if (mismatches < MAX_REPORTS) begin
                            $error("sample_out: expected %0d, actual %0d",
                                   want.sample, o_sample_out);
                        end
                        mismatches++;
                    end
                    if (o_clipped !== want.clipped) begin
                        if (mismatches < MAX_REPORTS) begin
                            $error("clipped: expected %0b, actual %0b", want.clipped, o_clipped);
                        end
                        mismatches++;
                    end
                    outputs_checked <= outputs_checked + 1;
                end
            end

            // Random stall bursts, switched off in stretches and in the tail.
            cycle_cnt++;
            if (cycle_cnt % 256 == 0) begin
                stalls_on = ($urandom_range(0, 2) != 0);
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!i_out_stall && stalls_on && !tail_phase &&
                         $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 11);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin : watchdog
        static int idle_cycles = 0;
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    // Stimulus generation, reset and end of run.
    initial begin
        t_eq_profile profile;
        int          pick;
        int          burst;

        // After reset every band passes its input straight through.
        for (int b = 0; b < BANDS; b++) begin
            for (int s = 0; s < NCOEF; s++) begin
                band_coef[b][s] = (s == COEF_B0) ? COEF_ONE : '0;
            end
            band_x1[b] = '0;
            band_x2[b] = '0;
            band_y1[b] = '0;
            band_y2[b] = '0;
        end

        // Bypass at the sample rails.
        add_sample(SAMPLE_BITS'(SAT_MAX));
        add_sample(SAMPLE_BITS'(SAT_MIN));
        add_sample('0);
        // Largest and most negative gains saturate both ways.
        add_coef(3'd0, COEF_B0, 32'sh7fff_ffff);
        add_sample(SAMPLE_BITS'(SAT_MAX));
        add_sample(SAMPLE_BITS'(SAT_MIN));
        add_coef(3'd0, COEF_B0, 32'sh8000_0000);
        add_sample(SAMPLE_BITS'(SAT_MIN));
        // Writes past the last band or selector, and the unused mode, change nothing.
        add_coef(3'(BANDS), COEF_B0, '0);
        add_coef(3'd1, 3'(int'(COEF_A2) + 1), '0);
        add_coef(3'd2, 3'd7, '0);
        add_control(MODE_RESERVED, 1'b0);
        add_sample(24'sd1);
        // Half-gain feedforward taps and small feedback exercise rounding of halves.
        add_coef(3'd0, COEF_B0, COEF_ONE);
        add_coef(3'd6, COEF_B1, COEF_ONE >>> 1);
        add_coef(3'd6, COEF_B2, -(COEF_ONE >>> 1));
        add_coef(3'd3, COEF_A1, COEF_ONE >>> 2);
        add_coef(3'd3, COEF_A2, -(COEF_ONE >>> 2));
        add_sample(24'sd4096);
        add_sample(-24'sd1);
        add_sample(24'sd1001);
        // History clear once the pipeline has fully drained.
        add_control(MODE_CLEAR, 1'b1);
        add_sample(SAMPLE_BITS'(SAT_MIN));
        add_sample(24'sd3);

        // Random phases: program a filter set, then stream samples with some noise.
        while (items_counted < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            profile = (pick < 5) ? PROFILE_MILD : (pick < 7) ? PROFILE_FLAT :
                      (pick < 9) ? PROFILE_HOT : PROFILE_WILD;
            if ($urandom_range(0, 2) == 0) begin
                add_control(MODE_CLEAR, $urandom_range(0, 9) == 0);
            end
            for (int b = 0; b < BANDS; b++) begin
                for (int s = 0; s < NCOEF; s++) begin
                    if ($urandom_range(0, 7) != 0) begin
                        add_coef(3'(b), 3'(s), pick_coef(profile, 3'(s)));
                    end
                end
            end
            burst = $urandom_range(20, 80);
            repeat (burst) begin
                case ($urandom_range(0, 29))
                    0:       add_control(MODE_RESERVED, 1'b0);
                    1:       add_coef(3'($urandom), 3'($urandom), COEF_BITS'($urandom));
                    2:       add_control(MODE_CLEAR, 1'b0);
                    default: add_sample(pick_sample());
                endcase
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!stim_done) @(posedge i_clk);
        while (outputs_checked != samples_predicted) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && equalized_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/cbeq_pkg.sv
design/cbeq_ctrl.sv
design/cbeq_dp.sv
design/cascaded_biquad_equalizer.sv
tb/sv/tb_cascaded_biquad_equalizer.sv
